>>> design/erj_pkg.sv
`default_nettype none

package erj_pkg;

    // Width and limits of every result field.
    localparam int OUT_W = 18;
    localparam logic signed [63:0] OUT_MAX = 64'sd131071;
    localparam logic signed [63:0] OUT_MIN = -64'sd131072;

    // A result field as it leaves the block.
    typedef logic signed [OUT_W-1:0] out_word_t;

    // Clamp an exact value to the signed result range.
    function automatic out_word_t sat_out(input logic signed [63:0] v);
        out_word_t r;
        if (v > OUT_MAX)
        begin
            r = out_word_t'(OUT_MAX);
        end
        else if (v < OUT_MIN)
        begin
            r = out_word_t'(OUT_MIN);
        end
        else
        begin
            r = out_word_t'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/epipolar_residual_jacobian.sv
`default_nettype none

// Epipolar residual and Jacobians for one point pair. Each transfer carries a
// rotation quaternion, a direction quaternion whose rotation matrix's third
// column is the translation direction, and two bearing vectors in signed
// fixed point with FRAC_BITS fractional bits; each result carries the
// residual, the three rotation Jacobian terms and the two sphere tangent
// terms, every one saturated to 18 bits. The block is a six-register
// pipeline (quaternion products, rotation entries, rotated bearing, cross
// products, final dot and cross products, saturation), so one item enters
// every cycle unless the input is stalled. A stalled output holds only its
// own register; empty stages upstream keep filling, and the input is
// stalled only when every stage holds an item.
module epipolar_residual_jacobian #(
    parameter int FRAC_BITS = 14
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      item_valid,
    output logic                     item_stall,
    input  wire  signed [15:0]       rot_w,
    input  wire  signed [15:0]       rot_x,
    input  wire  signed [15:0]       rot_y,
    input  wire  signed [15:0]       rot_z,
    input  wire  signed [15:0]       dir_w,
    input  wire  signed [15:0]       dir_x,
    input  wire  signed [15:0]       dir_y,
    input  wire  signed [15:0]       dir_z,
    input  wire         [47:0]       bearing_one,
    input  wire         [47:0]       bearing_two,
    output logic                     result_valid,
    input  wire                      result_stall,
    output erj_pkg::out_word_t       residual,
    output erj_pkg::out_word_t       jac_rot_x,
    output erj_pkg::out_word_t       jac_rot_y,
    output erj_pkg::out_word_t       jac_rot_z,
    output erj_pkg::out_word_t       jac_dir_a,
    output erj_pkg::out_word_t       jac_dir_b
);
    import erj_pkg::*;

    localparam int NSTG = 6;
    localparam int F    = FRAC_BITS;

    // Widths: each *T is an exact sum plus rounding headroom, each *W the
    // rounded value that the next stage sees.
    localparam int QT   = ((2*F+2 > 35) ? 2*F+2 : 35) + 1;
    localparam int RW   = QT - F;
    localparam int AT   = RW + 16 + 3;
    localparam int AW   = AT - F;
    localparam int PTT  = 16 + RW + 2;
    localparam int PTW  = PTT - F;
    localparam int TAT  = RW + AW + 2;
    localparam int TAW  = TAT - F;
    localparam int VT   = RW + PTW + 3;
    localparam int VW   = VT - F;
    localparam int DT   = 16 + AW + 2;
    localparam int DW   = DT - F + 1;
    localparam int REST = 16 + TAW + 3;
    localparam int RESW = REST - F;
    localparam int JQT  = VW + 16 + 2;
    localparam int JQW  = JQT - F + 1;
    localparam int JAT  = DW + RW + 4;
    localparam int JAW  = JAT - F;

    localparam logic signed [QT-1:0]   QONE   = QT'(1) << (2*F);
    localparam logic signed [QT-1:0]   QHALF  = QT'(1) << (F-1);
    localparam logic signed [AT-1:0]   AHALF  = AT'(1) << (F-1);
    localparam logic signed [PTT-1:0]  PHALF  = PTT'(1) << (F-1);
    localparam logic signed [TAT-1:0]  TAHALF = TAT'(1) << (F-1);
    localparam logic signed [VT-1:0]   VHALF  = VT'(1) << (F-1);
    localparam logic signed [DT-1:0]   DHALF  = DT'(1) << (F-1);
    localparam logic signed [REST-1:0] RHALF  = REST'(1) << (F-1);
    localparam logic signed [JQT-1:0]  JQHALF = JQT'(1) << (F-1);
    localparam logic signed [JAT-1:0]  JAHALF = JAT'(1) << (F-1);

    // Index pairs for the cross product terms.
    localparam int NX [3] = '{1, 2, 0};
    localparam int NY [3] = '{2, 0, 1};

    // Rotation matrix diagonal entry: one minus twice the two squares.
    function automatic logic signed [RW-1:0] rot_diag(input logic signed [31:0] a,
                                                      input logic signed [31:0] b);
        logic signed [QT-1:0] s;
        s = QONE - ((QT'(a) + QT'(b)) <<< 1) + QHALF;
        return s[QT-1:F];
    endfunction

    // Off-diagonal entry, twice a sum of products.
    function automatic logic signed [RW-1:0] rot_add(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [QT-1:0] s;
        s = ((QT'(a) + QT'(b)) <<< 1) + QHALF;
        return s[QT-1:F];
    endfunction

    // Off-diagonal entry, twice a difference of products.
    function automatic logic signed [RW-1:0] rot_sub(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [QT-1:0] s;
        s = ((QT'(a) - QT'(b)) <<< 1) + QHALF;
        return s[QT-1:F];
    endfunction

    // Handshake and stage valid bits.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // Stage 1: quaternion products and unpacked bearings.
    logic signed [31:0] qr_reg [9];
    logic signed [31:0] qr_next [9];
    logic signed [31:0] qd_reg [9];
    logic signed [31:0] qd_next [9];
    logic signed [15:0] p1_s1_reg [3];
    logic signed [15:0] p2_s1_reg [3];

    // Stage 2: rotation matrices.
    logic signed [RW-1:0] r_reg [3][3];
    logic signed [RW-1:0] r_next [3][3];
    logic signed [RW-1:0] rt_reg [3][3];
    logic signed [RW-1:0] rt_next [3][3];
    logic signed [15:0]   p1_s2_reg [3];
    logic signed [15:0]   p2_s2_reg [3];

    // Stage 3: rotated second bearing and p1 x t.
    logic signed [AW-1:0]  a_reg [3];
    logic signed [AW-1:0]  a_next [3];
    logic signed [PTW-1:0] pt_reg [3];
    logic signed [PTW-1:0] pt_next [3];
    logic signed [RW-1:0]  r_s3_reg [3][3];
    logic signed [RW-1:0]  rt_s3_reg [3][3];
    logic signed [15:0]    p1_s3_reg [3];
    logic signed [15:0]    p2_s3_reg [3];

    // Stage 4: t x a, R^T (p1 x t) and the negated p1 x a.
    logic signed [TAW-1:0] ta_reg [3];
    logic signed [TAW-1:0] ta_next [3];
    logic signed [VW-1:0]  v_reg [3];
    logic signed [VW-1:0]  v_next [3];
    logic signed [DW-1:0]  d_reg [3];
    logic signed [DW-1:0]  d_next [3];
    logic signed [RW-1:0]  c0_reg [3];
    logic signed [RW-1:0]  c1_reg [3];
    logic signed [15:0]    p1_s4_reg [3];
    logic signed [15:0]    p2_s4_reg [3];

    // Stage 5: unsaturated results.
    logic signed [RESW-1:0] res_reg;
    logic signed [RESW-1:0] res_next;
    logic signed [JQW-1:0]  jq_reg [3];
    logic signed [JQW-1:0]  jq_next [3];
    logic signed [JAW-1:0]  ja_reg;
    logic signed [JAW-1:0]  ja_next;
    logic signed [JAW-1:0]  jb_reg;
    logic signed [JAW-1:0]  jb_next;

    // Stage 6: output registers.
    out_word_t res_out_reg;
    out_word_t jqx_out_reg;
    out_word_t jqy_out_reg;
    out_word_t jqz_out_reg;
    out_word_t ja_out_reg;
    out_word_t jb_out_reg;

    // A stage takes a new item when it is empty or its content moves on.
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || !result_stall;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign item_stall   = !en[0];
    assign result_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= item_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1 products: xx, yy, zz, xy, wz, xz, wy, yz, wx.
    always_comb
    begin
        qr_next[0] = rot_x * rot_x;
        qr_next[1] = rot_y * rot_y;
        qr_next[2] = rot_z * rot_z;
        qr_next[3] = rot_x * rot_y;
        qr_next[4] = rot_w * rot_z;
        qr_next[5] = rot_x * rot_z;
        qr_next[6] = rot_w * rot_y;
        qr_next[7] = rot_y * rot_z;
        qr_next[8] = rot_w * rot_x;
        qd_next[0] = dir_x * dir_x;
        qd_next[1] = dir_y * dir_y;
        qd_next[2] = dir_z * dir_z;
        qd_next[3] = dir_x * dir_y;
        qd_next[4] = dir_w * dir_z;
        qd_next[5] = dir_x * dir_z;
        qd_next[6] = dir_w * dir_y;
        qd_next[7] = dir_y * dir_z;
        qd_next[8] = dir_w * dir_x;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            qr_reg <= qr_next;
            qd_reg <= qd_next;
            for (int i = 0; i < 3; i++)
            begin
                p1_s1_reg[i] <= signed'(bearing_one[16*i +: 16]);
                p2_s1_reg[i] <= signed'(bearing_two[16*i +: 16]);
            end
        end
    end

    // Stage 2: both rotation matrices from their products.
    always_comb
    begin
        r_next[0][0] = rot_diag(qr_reg[1], qr_reg[2]);
        r_next[0][1] = rot_sub(qr_reg[3], qr_reg[4]);
        r_next[0][2] = rot_add(qr_reg[5], qr_reg[6]);
        r_next[1][0] = rot_add(qr_reg[3], qr_reg[4]);
        r_next[1][1] = rot_diag(qr_reg[0], qr_reg[2]);
        r_next[1][2] = rot_sub(qr_reg[7], qr_reg[8]);
        r_next[2][0] = rot_sub(qr_reg[5], qr_reg[6]);
        r_next[2][1] = rot_add(qr_reg[7], qr_reg[8]);
        r_next[2][2] = rot_diag(qr_reg[0], qr_reg[1]);
        rt_next[0][0] = rot_diag(qd_reg[1], qd_reg[2]);
        rt_next[0][1] = rot_sub(qd_reg[3], qd_reg[4]);
        rt_next[0][2] = rot_add(qd_reg[5], qd_reg[6]);
        rt_next[1][0] = rot_add(qd_reg[3], qd_reg[4]);
        rt_next[1][1] = rot_diag(qd_reg[0], qd_reg[2]);
        rt_next[1][2] = rot_sub(qd_reg[7], qd_reg[8]);
        rt_next[2][0] = rot_sub(qd_reg[5], qd_reg[6]);
        rt_next[2][1] = rot_add(qd_reg[7], qd_reg[8]);
        rt_next[2][2] = rot_diag(qd_reg[0], qd_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            r_reg     <= r_next;
            rt_reg    <= rt_next;
            p1_s2_reg <= p1_s1_reg;
            p2_s2_reg <= p2_s1_reg;
        end
    end

    // Stage 3: a = R p2 and p1 x t, where t is the third column of Rt.
    always_comb
    begin
        logic signed [AT-1:0]  asum;
        logic signed [PTT-1:0] psum;
        for (int i = 0; i < 3; i++)
        begin
            asum = r_reg[i][0] * p2_s2_reg[0] + r_reg[i][1] * p2_s2_reg[1]
                 + r_reg[i][2] * p2_s2_reg[2] + AHALF;
            a_next[i] = asum[AT-1:F];
            psum = p1_s2_reg[NX[i]] * rt_reg[NY[i]][2]
                 - p1_s2_reg[NY[i]] * rt_reg[NX[i]][2] + PHALF;
            pt_next[i] = psum[PTT-1:F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            a_reg     <= a_next;
            pt_reg    <= pt_next;
            r_s3_reg  <= r_reg;
            rt_s3_reg <= rt_reg;
            p1_s3_reg <= p1_s2_reg;
            p2_s3_reg <= p2_s2_reg;
        end
    end

    // Stage 4: t x a, R^T (p1 x t) and d = -(p1 x a).
    always_comb
    begin
        logic signed [TAT-1:0] tsum;
        logic signed [VT-1:0]  vsum;
        logic signed [DT-1:0]  dsum;
        for (int i = 0; i < 3; i++)
        begin
            tsum = rt_s3_reg[NX[i]][2] * a_reg[NY[i]]
                 - rt_s3_reg[NY[i]][2] * a_reg[NX[i]] + TAHALF;
            ta_next[i] = tsum[TAT-1:F];
            vsum = r_s3_reg[0][i] * pt_reg[0] + r_s3_reg[1][i] * pt_reg[1]
                 + r_s3_reg[2][i] * pt_reg[2] + VHALF;
            v_next[i] = vsum[VT-1:F];
            dsum = p1_s3_reg[NX[i]] * a_reg[NY[i]]
                 - p1_s3_reg[NY[i]] * a_reg[NX[i]] + DHALF;
            d_next[i] = -DW'(signed'(dsum[DT-1:F]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            ta_reg    <= ta_next;
            v_reg     <= v_next;
            d_reg     <= d_next;
            p1_s4_reg <= p1_s3_reg;
            p2_s4_reg <= p2_s3_reg;
            for (int i = 0; i < 3; i++)
            begin
                c0_reg[i] <= rt_s3_reg[i][0];
                c1_reg[i] <= rt_s3_reg[i][1];
            end
        end
    end

    // Stage 5: residual, rotation terms and tangent projections.
    always_comb
    begin
        logic signed [REST-1:0] rsum;
        logic signed [JQT-1:0]  jsum;
        logic signed [JAT-1:0]  asum;
        logic signed [JAT-1:0]  bsum;
        rsum = p1_s4_reg[0] * ta_reg[0] + p1_s4_reg[1] * ta_reg[1]
             + p1_s4_reg[2] * ta_reg[2] + RHALF;
        res_next = rsum[REST-1:F];
        for (int i = 0; i < 3; i++)
        begin
            jsum = v_reg[NX[i]] * p2_s4_reg[NY[i]]
                 - v_reg[NY[i]] * p2_s4_reg[NX[i]] + JQHALF;
            jq_next[i] = -JQW'(signed'(jsum[JQT-1:F]));
        end
        asum = JAHALF - (d_reg[0] * c1_reg[0] + d_reg[1] * c1_reg[1]
                         + d_reg[2] * c1_reg[2]);
        ja_next = asum[JAT-1:F];
        bsum = d_reg[0] * c0_reg[0] + d_reg[1] * c0_reg[1]
             + d_reg[2] * c0_reg[2] + JAHALF;
        jb_next = bsum[JAT-1:F];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            res_reg <= res_next;
            jq_reg  <= jq_next;
            ja_reg  <= ja_next;
            jb_reg  <= jb_next;
        end
    end

    // Stage 6: saturation into the output registers.
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            res_out_reg <= sat_out(64'(res_reg));
            jqx_out_reg <= sat_out(64'(jq_reg[0]));
            jqy_out_reg <= sat_out(64'(jq_reg[1]));
            jqz_out_reg <= sat_out(64'(jq_reg[2]));
            ja_out_reg  <= sat_out(64'(ja_reg));
            jb_out_reg  <= sat_out(64'(jb_reg));
        end
    end

    assign residual  = res_out_reg;
    assign jac_rot_x = jqx_out_reg;
    assign jac_rot_y = jqy_out_reg;
    assign jac_rot_z = jqz_out_reg;
    assign jac_dir_a = ja_out_reg;
    assign jac_dir_b = jb_out_reg;

    // The input is held back only when every stage is full and the output stalls.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (vld_reg == {NSTG{1'b1}}) && result_stall)
        else $error("input stalled while the pipeline has room");

    // An item in the last arithmetic stage that moves on becomes a result.
    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-2] && en[NSTG-1] |=> result_valid)
        else $error("item lost between the last stage and the output");

    // A residual above range leaves the block clamped to the maximum.
    a_res_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTG-2] && en[NSTG-1] && (64'(res_reg) > OUT_MAX)
        |=> residual == out_word_t'(OUT_MAX))
        else $error("residual not saturated");

endmodule

`default_nettype wire

>>> verif/epipolar_residual_jacobian_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module epipolar_residual_jacobian_tb;

    import erj_pkg::*;

    localparam int FRAC = 14;
    localparam int PIPE_DEPTH = 6;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [15:0] Q_ONE = 16'sd16384;
    localparam logic signed [15:0] Q_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN = -16'sh8000;

    typedef struct packed {
        logic signed [15:0] rw, rx, ry, rz;
        logic signed [15:0] dw, dx, dy, dz;
        logic [47:0] b1, b2;
    } pair_t;

    typedef struct packed {
        out_word_t res, jx, jy, jz, ja, jb;
    } answer_t;

    typedef longint vec3_t [3];
    typedef longint mat3_t [3][3];

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic signed [15:0] rot_w, rot_x, rot_y, rot_z;
    logic signed [15:0] dir_w, dir_x, dir_y, dir_z;
    logic [47:0] bearing_one, bearing_two;
    logic result_valid;
    logic result_stall;
    out_word_t residual, jac_rot_x, jac_rot_y, jac_rot_z, jac_dir_a, jac_dir_b;

    answer_t expected_answers[$];
    int error_count;
    longint cycle_count;
    bit sender_gaps;
    bit receiver_gaps;

    epipolar_residual_jacobian dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .rot_w(rot_w), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
        .dir_w(dir_w), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .bearing_one(bearing_one), .bearing_two(bearing_two),
        .result_valid(result_valid), .result_stall(result_stall),
        .residual(residual), .jac_rot_x(jac_rot_x), .jac_rot_y(jac_rot_y),
        .jac_rot_z(jac_rot_z), .jac_dir_a(jac_dir_a), .jac_dir_b(jac_dir_b)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Round half up to the working precision.
    function automatic longint round_q(longint v);
        return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clamp_out(longint v);
        if (v > 131071)
        begin
            return 131071;
        end
        if (v < -131072)
        begin
            return -131072;
        end
        return v;
    endfunction

    function automatic mat3_t rotation_of(longint w, longint x, longint y, longint z);
        mat3_t m;
        longint one;
        one = longint'(1) << (2 * FRAC);
        m[0][0] = round_q(one - 2 * (y * y + z * z));
        m[0][1] = round_q(2 * (x * y - w * z));
        m[0][2] = round_q(2 * (x * z + w * y));
        m[1][0] = round_q(2 * (x * y + w * z));
        m[1][1] = round_q(one - 2 * (x * x + z * z));
        m[1][2] = round_q(2 * (y * z - w * x));
        m[2][0] = round_q(2 * (x * z - w * y));
        m[2][1] = round_q(2 * (y * z + w * x));
        m[2][2] = round_q(one - 2 * (x * x + y * y));
        return m;
    endfunction

    function automatic vec3_t cross_q(vec3_t a, vec3_t b);
        vec3_t c;
        c[0] = round_q(a[1] * b[2] - a[2] * b[1]);
        c[1] = round_q(a[2] * b[0] - a[0] * b[2]);
        c[2] = round_q(a[0] * b[1] - a[1] * b[0]);
        return c;
    endfunction

    function automatic longint dot_q(vec3_t a, vec3_t b);
        return round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    endfunction

    function automatic vec3_t unpack_bearing(logic [47:0] w);
        vec3_t v;
        v[0] = longint'($signed(w[15:0]));
        v[1] = longint'($signed(w[31:16]));
        v[2] = longint'($signed(w[47:32]));
        return v;
    endfunction

    // Residual and Jacobians of one point pair.
    function automatic answer_t epipolar_answer(pair_t p);
        mat3_t r, rt;
        vec3_t p1, p2, t, c0, c1n, a, ta, pt, v, jq, d;
        answer_t ans;
        r = rotation_of(p.rw, p.rx, p.ry, p.rz);
        rt = rotation_of(p.dw, p.dx, p.dy, p.dz);
        p1 = unpack_bearing(p.b1);
        p2 = unpack_bearing(p.b2);
        for (int i = 0; i < 3; i++)
        begin
            t[i] = rt[i][2];
            c0[i] = rt[i][0];
            c1n[i] = -rt[i][1];
            a[i] = round_q(r[i][0] * p2[0] + r[i][1] * p2[1] + r[i][2] * p2[2]);
        end
        ta = cross_q(t, a);
        pt = cross_q(p1, t);
        for (int i = 0; i < 3; i++)
        begin
            v[i] = round_q(r[0][i] * pt[0] + r[1][i] * pt[1] + r[2][i] * pt[2]);
        end
        jq = cross_q(v, p2);
        d = cross_q(p1, a);
        for (int i = 0; i < 3; i++)
        begin
            d[i] = -d[i];
        end
        ans.res = out_word_t'(clamp_out(dot_q(p1, ta)));
        ans.jx = out_word_t'(clamp_out(-jq[0]));
        ans.jy = out_word_t'(clamp_out(-jq[1]));
        ans.jz = out_word_t'(clamp_out(-jq[2]));
        ans.ja = out_word_t'(clamp_out(dot_q(d, c1n)));
        ans.jb = out_word_t'(clamp_out(dot_q(d, c0)));
        return ans;
    endfunction

    task automatic report_mismatch(string what, out_word_t got, out_word_t want);
        error_count++;
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    endtask

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("epipolar_residual_jacobian_tb failed");
            $finish;
        end
    end

    // Result checking at the rising edge.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                error_count++;
                $display("result transfer with no expectation waiting");
            end
            else
            begin
                want = expected_answers.pop_front();
                if (residual !== want.res) report_mismatch("residual", residual, want.res);
                if (jac_rot_x !== want.jx) report_mismatch("jac_rot_x", jac_rot_x, want.jx);
                if (jac_rot_y !== want.jy) report_mismatch("jac_rot_y", jac_rot_y, want.jy);
                if (jac_rot_z !== want.jz) report_mismatch("jac_rot_z", jac_rot_z, want.jz);
                if (jac_dir_a !== want.ja) report_mismatch("jac_dir_a", jac_dir_a, want.ja);
                if (jac_dir_b !== want.jb) report_mismatch("jac_dir_b", jac_dir_b, want.jb);
            end
        end
    end

    // Receiver stall bursts, driven at the falling edge.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Send one item and wait for its transfer.
    task automatic send_pair(pair_t p);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        item_valid <= 1'b1;
        {rot_w, rot_x, rot_y, rot_z} <= {p.rw, p.rx, p.ry, p.rz};
        {dir_w, dir_x, dir_y, dir_z} <= {p.dw, p.dx, p.dy, p.dz};
        bearing_one <= p.b1;
        bearing_two <= p.b2;
        expected_answers.push_back(epipolar_answer(p));
        @(posedge clk);
        while (item_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [47:0] random_bearing();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // A near-unit quaternion with small random noise.
    function automatic logic [63:0] near_unit_quat();
        int axis;
        logic signed [15:0] q [4];
        axis = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++)
        begin
            q[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
        end
        q[axis] = ($urandom_range(0, 1) != 0) ? Q_ONE - 16'($urandom_range(0, 3000))
                                              : -Q_ONE + 16'($urandom_range(0, 3000));
        return {q[0], q[1], q[2], q[3]};
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                {p.rw, p.rx, p.ry, p.rz} = {$urandom, $urandom};
                {p.dw, p.dx, p.dy, p.dz} = {$urandom, $urandom};
            end
            default:
            begin
                {p.rw, p.rx, p.ry, p.rz} = near_unit_quat();
                {p.dw, p.dx, p.dy, p.dz} = near_unit_quat();
            end
        endcase
        p.b1 = random_bearing();
        p.b2 = random_bearing();
        return p;
    endfunction

    task automatic wait_until_drained();
        while (expected_answers.size() != 0) @(negedge clk);
    endtask

    // Extremes of the fields, identity and half turns.
    task automatic test_directed();
        pair_t p;
        logic signed [15:0] ext [5];
        ext = '{16'sd0, Q_ONE, -Q_ONE, Q_MAX, Q_MIN};
        for (int i = 0; i < 5; i++)
        begin
            p.rw = ext[i]; p.rx = ext[(i + 1) % 5]; p.ry = ext[(i + 2) % 5];
            p.rz = ext[(i + 3) % 5];
            p.dw = ext[(i + 4) % 5]; p.dx = ext[i]; p.dy = ext[(i + 1) % 5];
            p.dz = ext[(i + 2) % 5];
            p.b1 = {ext[i], ext[(i + 2) % 5], ext[(i + 4) % 5]};
            p.b2 = {ext[(i + 1) % 5], ext[(i + 3) % 5], ext[i]};
            send_pair(p);
        end
        // Identity rotations with unit bearings.
        p = '0;
        p.rw = Q_ONE; p.dw = Q_ONE;
        p.b1 = {16'sd0, 16'sd0, Q_ONE};
        p.b2 = {16'sd0, Q_ONE, 16'sd0};
        send_pair(p);
        p.b1 = {Q_ONE, 16'sd0, 16'sd0};
        send_pair(p);
        // Half turns about each axis.
        p = '0; p.rx = Q_ONE; p.dy = Q_ONE; p.b1 = {3{Q_ONE}}; p.b2 = {3{-Q_ONE}};
        send_pair(p);
        p = '0; p.rz = Q_ONE; p.dx = Q_ONE; p.b1 = {3{Q_MAX}}; p.b2 = {3{Q_MIN}};
        send_pair(p);
        // All ones and all zeros, large unnormalised quaternions.
        p = '1; send_pair(p);
        p = '0; send_pair(p);
        p = '0;
        {p.rw, p.rx, p.ry, p.rz, p.dw, p.dx, p.dy, p.dz} = {8{Q_MIN}};
        p.b1 = {3{Q_MIN}}; p.b2 = {3{Q_MIN}};
        send_pair(p);
        {p.rw, p.rx, p.ry, p.rz, p.dw, p.dx, p.dy, p.dz} = {8{Q_MAX}};
        p.b1 = {3{Q_MAX}}; p.b2 = {3{Q_MAX}};
        send_pair(p);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_pair(random_pair());
        end
    endtask

    // The sender holds off until the pipeline has fully emptied.
    task automatic test_drain_pause();
        test_random(40);
        item_valid <= 1'b0;
        wait_until_drained();
        test_random(40);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        {rot_w, rot_x, rot_y, rot_z, dir_w, dir_x, dir_y, dir_z} = '0;
        bearing_one = '0;
        bearing_two = '0;
        error_count = 0;
        cycle_count = 0;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_drain_pause();
        test_random(1500);
        // Closing stretch with no idling on either side.
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        test_random(330);

        item_valid <= 1'b0;
        wait_until_drained();
        repeat (PIPE_DEPTH * 4) @(negedge clk);
        if (error_count == 0 && expected_answers.size() == 0)
        begin
            $display("epipolar_residual_jacobian_tb passed");
        end
        else
        begin
            $display("epipolar_residual_jacobian_tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> epipolar_residual_jacobian.f
design/erj_pkg.sv
design/epipolar_residual_jacobian.sv
verif/epipolar_residual_jacobian_tb.sv
